FILE: rtl/quoted_token_lexer_defines.svh
// ---------------------------------------------------------------------------
// Quoted token lexer assertion macros
// Shared assertion wrappers for the checker of the quoted token lexer.
// ---------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_LEXER_DEFINES_SVH
`define QUOTED_TOKEN_LEXER_DEFINES_SVH

// Assertion checked only while the block is out of reset.
`define QTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is also checked during reset.
`define QTL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/qtl_pkg.sv
// ---------------------------------------------------------------------------
// Quoted token lexer package
// Types, codes and constants shared by the lexer front end, queue and back end.
// ---------------------------------------------------------------------------
package qtl_pkg;

    // Line counter width and the width of the line field on the result stream.
    localparam int LINE_BITS   = 16;
    localparam int OUT_LINE_W  = 16;

    // Result stream layout.
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 2;
    localparam int NUM_MASKS   = 4;

    // Results one input byte can cause at most, and the bundle queue depth.
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Lexer modes.
    localparam logic [2:0] MODE_BETWEEN  = 3'd0;
    localparam logic [2:0] MODE_WORD     = 3'd1;
    localparam logic [2:0] MODE_QSTART   = 3'd2;
    localparam logic [2:0] MODE_QBODY    = 3'd3;
    localparam logic [2:0] MODE_COMMENT  = 3'd4;
    localparam logic [2:0] MODE_SKIPLINE = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NL_QUOTE   = 2'd1;
    localparam logic [1:0] ERR_WS_QUOTE   = 2'd2;
    localparam logic [1:0] ERR_QUOTE_WORD = 2'd3;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef logic [LINE_BITS-1:0] line_t;

    // One result within a bundle; the character and lines live in the bundle.
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] err;
        logic       use_new;
    } slot_t;

    // All results caused by one input byte.
    typedef struct packed {
        logic [1:0]                   cnt;
        logic [7:0]                   ch;
        line_t                        line_old;
        line_t                        line_new;
        slot_t [MAX_RESULTS-1:0]      slots;
    } bundle_t;

    // Push and pop handshakes of the bundle queue.
    typedef struct packed {
        logic    valid;
        bundle_t data;
    } push_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } head_t;

endpackage

FILE: rtl/qtl_front.sv
// ---------------------------------------------------------------------------
// Quoted token lexer front end
// Accepts bytes, runs the lexer state and packs each byte's results.
// ---------------------------------------------------------------------------
module qtl_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [qtl_pkg::IN_DATA_W-1:0] s_tdata,  // [7:0] char_in
    input  logic                     s_tlast,       // end_of_input
    input  logic [255:0]             special_mask,
    input  logic                     q_full,
    output qtl_pkg::push_t           push
);
    import qtl_pkg::*;

    logic [2:0] mode_reg, mode_next;
    line_t      line_reg, line_next;
    bundle_t    bundle;
    logic [7:0] c;
    logic       spec, ws, accept;

    // Between-token sub-step results.
    logic [2:0] b_mode;
    logic [1:0] b_cnt;
    line_t      b_line;

    assign c        = s_tdata[7:0];
    assign spec     = special_mask[c];
    assign ws       = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Handling of a byte between tokens: a newline counts before anything else.
    always_comb begin
        b_line = (c == CH_NL) ? line_t'(line_reg + 1'b1) : line_reg;
        b_cnt  = 2'd0;
        b_mode = MODE_BETWEEN;
        priority if (spec) begin
            b_cnt = 2'd2;
        end else if (c == CH_QUOTE) begin
            b_mode = MODE_QSTART;
        end else if (ws) begin
            b_mode = MODE_BETWEEN;
        end else if (c == CH_HASH) begin
            b_mode = MODE_COMMENT;
        end else if (c == CH_BSL) begin
            b_mode = MODE_SKIPLINE;
        end else begin
            b_cnt  = 2'd1;
            b_mode = MODE_WORD;
        end
    end

    // Main lexer step and result bundle.
    always_comb begin
        mode_next       = mode_reg;
        line_next       = line_reg;
        bundle          = '0;
        bundle.ch       = c;
        if (s_tlast) begin
            if (mode_reg == MODE_WORD || mode_reg == MODE_QBODY) begin
                bundle.cnt           = 2'd1;
                bundle.slots[0].kind = KIND_END;
            end
            mode_next = MODE_BETWEEN;
        end else begin
            unique case (mode_reg)
                MODE_WORD: begin
                    priority if (ws || spec) begin
                        // End marker, then the separator is lexed between tokens.
                        bundle.slots[0].kind    = KIND_END;
                        bundle.slots[1].kind    = KIND_CHAR;
                        bundle.slots[1].use_new = 1'b1;
                        bundle.slots[2].kind    = KIND_END;
                        bundle.slots[2].use_new = 1'b1;
                        bundle.cnt              = 2'(2'd1 + b_cnt);
                        mode_next               = b_mode;
                        line_next               = b_line;
                    end else if (c == CH_QUOTE) begin
                        bundle.cnt           = 2'd1;
                        bundle.slots[0].kind = KIND_ERR;
                        bundle.slots[0].err  = ERR_QUOTE_WORD;
                        mode_next            = MODE_BETWEEN;
                    end else begin
                        bundle.cnt           = 2'd1;
                        bundle.slots[0].kind = KIND_CHAR;
                    end
                end
                MODE_QSTART, MODE_QBODY: begin
                    priority if (c == CH_QUOTE) begin
                        if (mode_reg == MODE_QBODY) begin
                            bundle.cnt           = 2'd1;
                            bundle.slots[0].kind = KIND_END;
                        end
                        mode_next = MODE_BETWEEN;
                    end else if (c == CH_NL) begin
                        // Reported with the line before the newline counts.
                        bundle.cnt           = 2'd1;
                        bundle.slots[0].kind = KIND_ERR;
                        bundle.slots[0].err  = ERR_NL_QUOTE;
                        line_next            = line_t'(line_reg + 1'b1);
                        mode_next            = MODE_BETWEEN;
                    end else if (mode_reg == MODE_QSTART && ws) begin
                        bundle.cnt           = 2'd1;
                        bundle.slots[0].kind = KIND_ERR;
                        bundle.slots[0].err  = ERR_WS_QUOTE;
                        mode_next            = MODE_BETWEEN;
                    end else begin
                        bundle.cnt           = 2'd1;
                        bundle.slots[0].kind = KIND_CHAR;
                        mode_next            = MODE_QBODY;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        bundle.slots[0].kind    = KIND_CHAR;
                        bundle.slots[0].use_new = 1'b1;
                        bundle.slots[1].kind    = KIND_END;
                        bundle.slots[1].use_new = 1'b1;
                        bundle.cnt              = b_cnt;
                        mode_next               = b_mode;
                        line_next               = b_line;
                    end
                end
                MODE_SKIPLINE: begin
                    if (c == CH_NL) begin
                        line_next = line_t'(line_reg + 1'b1);
                        mode_next = MODE_BETWEEN;
                    end
                end
                default: begin
                    bundle.slots[0].kind    = KIND_CHAR;
                    bundle.slots[0].use_new = 1'b1;
                    bundle.slots[1].kind    = KIND_END;
                    bundle.slots[1].use_new = 1'b1;
                    bundle.cnt              = b_cnt;
                    mode_next               = b_mode;
                    line_next               = b_line;
                end
            endcase
        end
        bundle.line_old = line_reg;
        bundle.line_new = line_next;
    end

    // Bytes that cause no result never enter the queue.
    assign push.valid = accept && (bundle.cnt != 2'd0);
    assign push.data  = bundle;

    // Lexer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BETWEEN;
            line_reg <= line_t'(1);
        end else if (accept) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

endmodule

FILE: rtl/qtl_queue.sv
// ---------------------------------------------------------------------------
// Quoted token lexer bundle queue
// Short first-in first-out buffer of result bundles between front and back.
// ---------------------------------------------------------------------------
module qtl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  qtl_pkg::push_t  push,
    input  logic            pop,
    output logic            full,
    output qtl_pkg::head_t  head
);
    import qtl_pkg::*;

    bundle_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

FILE: rtl/qtl_back.sv
// ---------------------------------------------------------------------------
// Quoted token lexer back end
// Unpacks queued bundles into single results behind an output register.
// ---------------------------------------------------------------------------
module qtl_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  qtl_pkg::head_t                 head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [qtl_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] char_out, [9:8] error_code,
                                                     // [25:10] line, rest zero
    output logic [1:0]                     m_tuser,  // kind
    output logic                           m_tlast   // last
);
    import qtl_pkg::*;

    logic [1:0]            idx_reg;
    logic                  m_tvalid_reg;
    logic [7:0]            char_reg;
    logic [1:0]            err_reg, kind_reg;
    logic [OUT_LINE_W-1:0] line_reg;
    logic                  last_reg;
    slot_t                 slot;
    logic                  load, is_last;

    assign slot    = head.data.slots[idx_reg];
    assign is_last = (idx_reg == 2'(head.data.cnt - 2'd1));
    assign load    = head.valid && (!m_tvalid_reg || m_tready);
    assign pop     = load && is_last;

    // Slot counter walks the results of the bundle at the head of the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg      <= is_last ? 2'd0 : 2'(idx_reg + 2'd1);
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= slot.kind;
            err_reg  <= slot.err;
            char_reg <= (slot.kind == KIND_CHAR) ? head.data.ch : 8'd0;
            line_reg <= slot.use_new ? OUT_LINE_W'(head.data.line_new)
                                     : OUT_LINE_W'(head.data.line_old);
            last_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = OUT_DATA_W'({line_reg, err_reg, char_reg});

endmodule

FILE: rtl/quoted_token_lexer.sv
// ---------------------------------------------------------------------------
// Quoted token lexer
// Splits a byte stream into tokens and streams them out one character a time.
// ---------------------------------------------------------------------------
// The lexer takes one byte per cycle on the input stream as long as its
// four-entry bundle queue has room. Each byte causes zero to three results;
// the output register sends one result per cycle while m_tready is high, and
// the queue absorbs the bursts of a byte that causes three results (a word
// closed by a special character). An input transfer passes a queue entry
// and then the output register. The special-character mask is to be written
// by the user through the configuration port only while the block is idle;
// the block does not enforce this. Reset clears the mask registers.
module quoted_token_lexer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [qtl_pkg::IN_DATA_W-1:0]      s_tdata,  // [7:0] char_in
    input  logic                               s_tlast,  // end_of_input
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [qtl_pkg::OUT_DATA_W-1:0]     m_tdata,  // [7:0] char_out, [9:8] error_code,
                                                         // [25:10] line, rest zero
    output logic [1:0]                         m_tuser,  // kind
    output logic                               m_tlast,  // last
    input  logic                               cfg_wr_en,
    input  logic [qtl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [qtl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import qtl_pkg::*;

    logic [NUM_MASKS-1:0][CFG_DATA_W-1:0] mask_reg;
    push_t push;
    head_t head;
    logic  q_full, pop;

    // Special-character mask registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cfg_wr_en) begin
            mask_reg[cfg_addr] <= cfg_wdata;
        end
    end

    qtl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .special_mask (mask_reg),
        .q_full       (q_full),
        .push         (push)
    );

    qtl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .head    (head)
    );

    qtl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/qtl_checker.sv
// ---------------------------------------------------------------------------
// Quoted token lexer checker
// Port-level assertions on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "quoted_token_lexer_defines.svh"

module qtl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [qtl_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           m_tlast
);
    import qtl_pkg::*;

    // No result is offered in the cycle after reset.
    `QTL_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result keeps its payload.
    `QTL_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
                "stalled result changed")

    // A syntax error always closes the results of its byte.
    `QTL_ASSERT(a_err_last, m_tvalid && m_tuser == KIND_ERR |-> m_tlast, "error not last result")

    // The error code is set exactly on error results.
    `QTL_ASSERT(a_err_code,
                m_tvalid |-> ((m_tuser == KIND_ERR) == (m_tdata[9:8] != ERR_NONE)),
                "error code mismatch")

    // Only token characters carry a character.
    `QTL_ASSERT(a_char_zero, m_tvalid && m_tuser != KIND_CHAR |-> m_tdata[7:0] == 8'd0,
                "character on non-character result")

endmodule

bind quoted_token_lexer qtl_checker u_qtl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
